[src/coincidence_histogram_2d_windows_assert.svh]
// Assertion macros used by the port checker of the coincidence histogram.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef COINCIDENCE_HISTOGRAM_2D_WINDOWS_ASSERT_SVH
`define COINCIDENCE_HISTOGRAM_2D_WINDOWS_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define CHW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset
`define CHW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

[src/chist2d_pkg.sv]
// Shared types, constants and helper functions of the coincidence histogram.
// No dependencies; every other module but the port checker imports this package.
package chist2d_pkg;

	localparam int MAX_BINS = 128;
	localparam int BIN_W    = $clog2(MAX_BINS);
	localparam int RC_W     = 7;
	localparam int IDX_W    = (BIN_W > RC_W) ? BIN_W : RC_W;
	localparam int DEPTH    = MAX_BINS * MAX_BINS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int EN_W     = 16;
	localparam int CNT_W    = 32;
	localparam int NBINS_W  = 8;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_BINS_A   = 3'd0,
		REG_BINS_B   = 3'd1,
		REG_WIDTH_A  = 3'd2,
		REG_WIDTH_B  = 3'd3,
		REG_W1_LOW   = 3'd4,
		REG_W1_HIGH  = 3'd5,
		REG_W2_LOW   = 3'd6,
		REG_W2_HIGH  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [NBINS_W-1:0] bins_a;
		logic [NBINS_W-1:0] bins_b;
		logic [EN_W-1:0]    width_a;
		logic [EN_W-1:0]    width_b;
		logic [EN_W-1:0]    w1_lo;
		logic [EN_W-1:0]    w1_hi;
		logic [EN_W-1:0]    w2_lo;
		logic [EN_W-1:0]    w2_hi;
	} cfg_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic cap;
		logic div_start;
		logic bin_load;
		logic mem_rd;
		logic wb;
		logic clr_wr;
		logic out_load;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic div_done;
		logic clr_last;
	} dp_sts_t;

	// last bin index in use; zero bins act as one, too many act as MAX_BINS
	function automatic logic [IDX_W-1:0] last_bin(input logic [NBINS_W-1:0] n);
		logic [IDX_W-1:0] r;
		if (int'(n) > MAX_BINS)
			r = IDX_W'(MAX_BINS - 1);
		else if (n == '0)
			r = '0;
		else
			r = IDX_W'(n - NBINS_W'(1));
		return r;
	endfunction

	// saturate a quotient into the last bin in use
	function automatic logic [IDX_W-1:0] clamp_bin(input logic [EN_W-1:0] q,
			input logic [IDX_W-1:0] last);
		return (32'(q) > 32'(last)) ? last : IDX_W'(q);
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

	// half-open window test, empty when high <= low
	function automatic logic in_win(input logic [EN_W-1:0] e, input logic [EN_W-1:0] lo,
			input logic [EN_W-1:0] hi);
		return (e >= lo) && (e < hi);
	endfunction

endpackage

[src/chist2d_div.sv]
// Restoring divider, one quotient bit per cycle, for the energy binning.
// Depends on chist2d_pkg for the energy width.
module chist2d_div import chist2d_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [EN_W-1:0] dividend,
	input  logic [EN_W-1:0] divisor,
	output logic            done,
	output logic [EN_W-1:0] quotient
);

	localparam int STEP_W = $clog2(EN_W + 1);

	logic [EN_W-1:0]   rem_q;
	logic [EN_W-1:0]   quo_q;
	logic [EN_W-1:0]   dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [EN_W:0]     shifted;
	logic [EN_W+1:0]   diff;

	// shift in the next dividend bit and try the subtraction
	// (a zero divisor never borrows, so the quotient comes out all ones)
	assign shifted = {rem_q, quo_q[EN_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(EN_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= diff[EN_W+1] ? shifted[EN_W-1:0] : diff[EN_W-1:0];
			quo_q <= {quo_q[EN_W-2:0], ~diff[EN_W+1]};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[src/chist2d_regs.sv]
// APB-style configuration register file of the coincidence histogram.
// Depends on chist2d_pkg for the register map and the cfg_t bundle.
module chist2d_regs import chist2d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;

	// write the addressed register at the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bins_a  <= NBINS_W'(100);
			cfg_q.bins_b  <= NBINS_W'(100);
			cfg_q.width_a <= EN_W'(30);
			cfg_q.width_b <= EN_W'(30);
			cfg_q.w1_lo   <= '0;
			cfg_q.w1_hi   <= '0;
			cfg_q.w2_lo   <= '0;
			cfg_q.w2_hi   <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_BINS_A:  cfg_q.bins_a  <= pwdata[NBINS_W-1:0];
				REG_BINS_B:  cfg_q.bins_b  <= pwdata[NBINS_W-1:0];
				REG_WIDTH_A: cfg_q.width_a <= pwdata[EN_W-1:0];
				REG_WIDTH_B: cfg_q.width_b <= pwdata[EN_W-1:0];
				REG_W1_LOW:  cfg_q.w1_lo   <= pwdata[EN_W-1:0];
				REG_W1_HIGH: cfg_q.w1_hi   <= pwdata[EN_W-1:0];
				REG_W2_LOW:  cfg_q.w2_lo   <= pwdata[EN_W-1:0];
				REG_W2_HIGH: cfg_q.w2_hi   <= pwdata[EN_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_BINS_A:  prdata = PDATA_W'(cfg_q.bins_a);
			REG_BINS_B:  prdata = PDATA_W'(cfg_q.bins_b);
			REG_WIDTH_A: prdata = PDATA_W'(cfg_q.width_a);
			REG_WIDTH_B: prdata = PDATA_W'(cfg_q.width_b);
			REG_W1_LOW:  prdata = PDATA_W'(cfg_q.w1_lo);
			REG_W1_HIGH: prdata = PDATA_W'(cfg_q.w1_hi);
			REG_W2_LOW:  prdata = PDATA_W'(cfg_q.w2_lo);
			REG_W2_HIGH: prdata = PDATA_W'(cfg_q.w2_hi);
			default:     prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign cfg    = cfg_q;

endmodule

[src/chist2d_ctrl.sv]
// Controller state machine of the coincidence histogram: sequences binning,
// bin memory access, clearing and result hand-off. Depends on chist2d_pkg.
module chist2d_ctrl import chist2d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_op,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_sts_t    sts,
	output dp_cmd_t    ctl
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DIV,
		S_RD,
		S_WB,
		S_CLEAR,
		S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;
	op_t    op;

	assign op        = op_t'(in_op);
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// decode commands from the current state
	always_comb begin
		ctl = '0;
		case (state_q)
			S_INIT, S_CLEAR: ctl.clr_wr = 1'b1;
			S_IDLE: begin
				ctl.cap       = accept;
				ctl.div_start = accept && (op == OP_RECORD);
			end
			S_DIV:   ctl.bin_load = sts.div_done;
			S_RD:    ctl.mem_rd   = 1'b1;
			S_WB:    ctl.wb       = 1'b1;
			S_OUT:   ctl.out_load = slot_free;
			default: ctl = '0;
		endcase
	end

	// hold state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_INIT: begin
					if (sts.clr_last)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						case (op)
							OP_RECORD: state_q <= S_DIV;
							OP_READ:   state_q <= S_RD;
							OP_CLEAR:  state_q <= S_CLEAR;
							default:   state_q <= S_OUT;
						endcase
					end
				end
				S_DIV: begin
					if (sts.div_done)
						state_q <= S_RD;
				end
				S_RD:    state_q <= S_WB;
				S_WB:    state_q <= S_OUT;
				S_CLEAR: begin
					if (sts.clr_last)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/chist2d_dp.sv]
// Datapath of the coincidence histogram: binning dividers, bin memory,
// window counters and the result register. Depends on chist2d_pkg, chist2d_div.
module chist2d_dp import chist2d_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic [1:0]       in_op,
	input  logic [EN_W-1:0]  energy_a,
	input  logic [EN_W-1:0]  energy_b,
	input  logic [RC_W-1:0]  read_row,
	input  logic [RC_W-1:0]  read_col,
	input  dp_cmd_t          ctl,
	output dp_sts_t          sts,
	output logic [RC_W-1:0]  row,
	output logic [RC_W-1:0]  col,
	output logic [CNT_W-1:0] bin_count,
	output logic [CNT_W-1:0] both_in_one,
	output logic [CNT_W-1:0] both_in_two,
	output logic [CNT_W-1:0] both_in_union,
	output logic [CNT_W-1:0] crossed_windows
);

	logic [CNT_W-1:0]  mem [DEPTH];
	logic [CNT_W-1:0]  rdata_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] addr;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  one_q, two_q, uni_q, crs_q;
	op_t               op_q;
	logic              rd_ok_q;
	logic              f_one_q, f_two_q, f_uni_q, f_crs_q;
	logic              done_a, done_b;
	logic [EN_W-1:0]   quo_a, quo_b;
	logic              a1, a2, b1, b2;
	logic              rec_wb;
	logic [CNT_W-1:0]  inc;

	// one divider per axis, run side by side
	chist2d_div u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (energy_a),
		.divisor  (cfg.width_a),
		.done     (done_a),
		.quotient (quo_a)
	);

	chist2d_div u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (energy_b),
		.divisor  (cfg.width_b),
		.done     (done_b),
		.quotient (quo_b)
	);

	// window membership of the incoming word
	assign a1 = in_win(energy_a, cfg.w1_lo, cfg.w1_hi);
	assign a2 = in_win(energy_a, cfg.w2_lo, cfg.w2_hi);
	assign b1 = in_win(energy_b, cfg.w1_lo, cfg.w1_hi);
	assign b2 = in_win(energy_b, cfg.w2_lo, cfg.w2_hi);

	assign addr   = ADDR_W'(int'(row_q) * MAX_BINS + int'(col_q));
	assign rec_wb = ctl.wb && (op_q == OP_RECORD);
	assign inc    = sat_inc(rdata_q);

	assign sts.div_done = done_a && done_b;
	assign sts.clr_last = (clr_q == ADDR_W'(DEPTH - 1));

	// capture the word, then the bin indices, then the count
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			op_q    <= op_t'(in_op);
			f_one_q <= a1 && b1;
			f_two_q <= a2 && b2;
			f_uni_q <= (a1 || a2) && (b1 || b2);
			f_crs_q <= (a1 && b2) || (a2 && b1);
			rd_ok_q <= (int'(read_row) < MAX_BINS) && (int'(read_col) < MAX_BINS);
			cnt_q   <= '0;
			if (op_t'(in_op) == OP_READ) begin
				row_q <= IDX_W'(read_row);
				col_q <= IDX_W'(read_col);
			end else begin
				row_q <= '0;
				col_q <= '0;
			end
		end
		if (ctl.bin_load) begin
			row_q <= clamp_bin(quo_a, last_bin(cfg.bins_a));
			col_q <= clamp_bin(quo_b, last_bin(cfg.bins_b));
		end
		if (ctl.wb) begin
			if (op_q == OP_RECORD)
				cnt_q <= inc;
			else if (rd_ok_q)
				cnt_q <= rdata_q;
			else
				cnt_q <= '0;
		end
		if (ctl.out_load) begin
			row             <= RC_W'(row_q);
			col             <= RC_W'(col_q);
			bin_count       <= cnt_q;
			both_in_one     <= one_q;
			both_in_two     <= two_q;
			both_in_union   <= uni_q;
			crossed_windows <= crs_q;
		end
	end

	// bin memory: clear sweep or read-modify-write, registered read
	always_ff @(posedge clk) begin
		if (ctl.clr_wr)
			mem[clr_q] <= '0;
		else if (rec_wb)
			mem[addr] <= inc;
		if (ctl.mem_rd)
			rdata_q <= mem[addr];
	end

	// advance the clearing address, wrap after the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (ctl.clr_wr)
			clr_q <= sts.clr_last ? '0 : clr_q + ADDR_W'(1);
	end

	// window counters survive a clear of the bin memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_q <= '0;
			two_q <= '0;
			uni_q <= '0;
			crs_q <= '0;
		end else if (rec_wb) begin
			if (f_one_q) one_q <= sat_inc(one_q);
			if (f_two_q) two_q <= sat_inc(two_q);
			if (f_uni_q) uni_q <= sat_inc(uni_q);
			if (f_crs_q) crs_q <= sat_inc(crs_q);
		end
	end

endmodule

[src/coincidence_histogram_2d_windows.sv]
// Two-detector coincidence spectrum engine. Each word on the input channel is a
// command: record an event pair (energy_a, energy_b), read one 2D bin, or clear
// the 128 x 128 bin memory. Every word gives exactly one result word with the
// bin touched or read, its 32-bit saturating count, and the four window
// counters. One word is in work at a time. A record runs two restoring dividers
// (one per axis, in parallel) to find the bins, then one read and one write of
// the single-port bin memory; a read only reads the memory. A clear sweeps the
// memory one entry a cycle. After reset the same clearing pass runs with
// in_ready low; configuration writes are taken throughout. A finished result
// waits in the output register while the next word is accepted. Depends on
// chist2d_pkg and the submodules.
module coincidence_histogram_2d_windows import chist2d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [EN_W-1:0]    energy_a,
	input  logic [EN_W-1:0]    energy_b,
	input  logic [RC_W-1:0]    read_row,
	input  logic [RC_W-1:0]    read_col,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RC_W-1:0]    row,
	output logic [RC_W-1:0]    col,
	output logic [CNT_W-1:0]   bin_count,
	output logic [CNT_W-1:0]   both_in_one,
	output logic [CNT_W-1:0]   both_in_two,
	output logic [CNT_W-1:0]   both_in_union,
	output logic [CNT_W-1:0]   crossed_windows
);

	cfg_t    cfg;
	dp_cmd_t ctl;
	dp_sts_t sts;

	chist2d_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	chist2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_op     (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	chist2d_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.in_op           (cmd),
		.energy_a        (energy_a),
		.energy_b        (energy_b),
		.read_row        (read_row),
		.read_col        (read_col),
		.ctl             (ctl),
		.sts             (sts),
		.row             (row),
		.col             (col),
		.bin_count       (bin_count),
		.both_in_one     (both_in_one),
		.both_in_two     (both_in_two),
		.both_in_union   (both_in_union),
		.crossed_windows (crossed_windows)
	);

endmodule

[src/chist2d_chk.sv]
// Port-level checker of the coincidence histogram, bound to the top level.
// Depends on coincidence_histogram_2d_windows_assert.svh for the macros.
`include "coincidence_histogram_2d_windows_assert.svh"

module chist2d_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] bin_count,
	input logic [31:0] both_in_one,
	input logic [31:0] both_in_two,
	input logic [31:0] both_in_union,
	input logic [31:0] crossed_windows
);

	logic [31:0] last_union_q;

	// hold the union counter of the last delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_union_q <= '0;
		else if (out_valid && out_ready)
			last_union_q <= both_in_union;
	end

	// a stalled result word keeps its count
	`CHW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bin_count))

	// one word in work at a time
	`CHW_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

	// every window counter event is also a union event
	`CHW_ASSERT_NOW(a_union_covers, out_valid, (both_in_one <= both_in_union) && (both_in_two <= both_in_union) && (crossed_windows <= both_in_union))

	// the union counter only grows across delivered words
	`CHW_ASSERT_NOW(a_union_grows, out_valid && out_ready, both_in_union >= last_union_q)

endmodule

bind coincidence_histogram_2d_windows chist2d_chk u_chk (.*);

[verif/chist2d_report_check.sv]
// Prediction and comparison of result words for the coincidence histogram.
// Watches the APB port and both channels of the block; depends on chist2d_pkg.
module chist2d_report_check import chist2d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [EN_W-1:0]    energy_a,
	input  logic [EN_W-1:0]    energy_b,
	input  logic [RC_W-1:0]    read_row,
	input  logic [RC_W-1:0]    read_col,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [RC_W-1:0]    row,
	input  logic [RC_W-1:0]    col,
	input  logic [CNT_W-1:0]   bin_count,
	input  logic [CNT_W-1:0]   both_in_one,
	input  logic [CNT_W-1:0]   both_in_two,
	input  logic [CNT_W-1:0]   both_in_union,
	input  logic [CNT_W-1:0]   crossed_windows,
	output int                 mismatches,
	output int                 outstanding,
	output int                 records_seen,
	output int                 reads_seen,
	output int                 clears_seen,
	output int                 results_checked
);

	typedef struct packed {
		logic [RC_W-1:0]  row;
		logic [RC_W-1:0]  col;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] both_one;
		logic [CNT_W-1:0] both_two;
		logic [CNT_W-1:0] both_union;
		logic [CNT_W-1:0] crossed;
	} bin_report_t;

	// own copy of the block's state
	cfg_t             cfg;
	logic [CNT_W-1:0] bin_mem [DEPTH];
	logic [CNT_W-1:0] cnt_one, cnt_two, cnt_union, cnt_cross;
	bin_report_t      predicted_reports [$];

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic holds(input logic [EN_W-1:0] e, input logic [EN_W-1:0] lo,
			input logic [EN_W-1:0] hi);
		return (e >= lo) && (e < hi);
	endfunction

	// uniform bin from zero, saturating into the last bin in use
	function automatic logic [RC_W-1:0] axis_bin(input logic [EN_W-1:0] e,
			input logic [EN_W-1:0] w, input logic [NBINS_W-1:0] n);
		int used;
		int q;
		used = (n > MAX_BINS) ? MAX_BINS : ((n == 0) ? 1 : int'(n));
		if (w == 0)
			return RC_W'(used - 1);
		q = int'(e / w);
		return RC_W'((q > used - 1) ? used - 1 : q);
	endfunction

	// advance the state by one command word and give its result word
	function automatic bin_report_t apply_command(input op_t c, input logic [EN_W-1:0] ea,
			input logic [EN_W-1:0] eb, input logic [RC_W-1:0] rr, input logic [RC_W-1:0] rc);
		bin_report_t r;
		logic a1, a2, b1, b2;
		logic [ADDR_W-1:0] addr;
		r = '0;
		case (c)
			OP_RECORD: begin
				a1 = holds(ea, cfg.w1_lo, cfg.w1_hi);
				a2 = holds(ea, cfg.w2_lo, cfg.w2_hi);
				b1 = holds(eb, cfg.w1_lo, cfg.w1_hi);
				b2 = holds(eb, cfg.w2_lo, cfg.w2_hi);
				r.row = axis_bin(ea, cfg.width_a, cfg.bins_a);
				r.col = axis_bin(eb, cfg.width_b, cfg.bins_b);
				addr = {r.row, r.col};
				bin_mem[addr] = bump(bin_mem[addr]);
				r.count = bin_mem[addr];
				if (a1 && b1)
					cnt_one = bump(cnt_one);
				if (a2 && b2)
					cnt_two = bump(cnt_two);
				if ((a1 || a2) && (b1 || b2))
					cnt_union = bump(cnt_union);
				if ((a1 && b2) || (a2 && b1))
					cnt_cross = bump(cnt_cross);
			end
			OP_READ: begin
				r.row = rr;
				r.col = rc;
				r.count = bin_mem[{rr, rc}];
			end
			OP_CLEAR: begin
				for (int i = 0; i < DEPTH; i++)
					bin_mem[i] = '0;
			end
			default: begin
			end
		endcase
		r.both_one = cnt_one;
		r.both_two = cnt_two;
		r.both_union = cnt_union;
		r.crossed = cnt_cross;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bin_report_t want;
		if (!arst_n) begin
			cfg = {8'd100, 8'd100, 16'd30, 16'd30, 16'd0, 16'd0, 16'd0, 16'd0};
			for (int i = 0; i < DEPTH; i++)
				bin_mem[i] = '0;
			cnt_one = '0;
			cnt_two = '0;
			cnt_union = '0;
			cnt_cross = '0;
			predicted_reports.delete();
			mismatches = 0;
			outstanding = 0;
			records_seen = 0;
			reads_seen = 0;
			clears_seen = 0;
			results_checked = 0;
		end else begin
			// compare a result word with the oldest prediction
			if (out_valid && out_ready) begin
				if (predicted_reports.size() == 0) begin
					mismatches++;
					$display("%0t: result word with none expected, row %0d col %0d count %0d",
						$time, row, col, bin_count);
				end else begin
					want = predicted_reports.pop_front();
					check_field("row", CNT_W'(want.row), CNT_W'(row));
					check_field("col", CNT_W'(want.col), CNT_W'(col));
					check_field("bin_count", want.count, bin_count);
					check_field("both_in_one", want.both_one, both_in_one);
					check_field("both_in_two", want.both_two, both_in_two);
					check_field("both_in_union", want.both_union, both_in_union);
					check_field("crossed_windows", want.crossed, crossed_windows);
					results_checked++;
				end
			end
			// predict the result of an accepted command word
			if (in_valid && in_ready) begin
				predicted_reports.push_back(apply_command(op_t'(cmd), energy_a, energy_b,
					read_row, read_col));
				case (op_t'(cmd))
					OP_RECORD: records_seen++;
					OP_READ:   reads_seen++;
					OP_CLEAR:  clears_seen++;
					default: begin
					end
				endcase
			end
			// track register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_BINS_A:  cfg.bins_a = pwdata[7:0];
					REG_BINS_B:  cfg.bins_b = pwdata[7:0];
					REG_WIDTH_A: cfg.width_a = pwdata[15:0];
					REG_WIDTH_B: cfg.width_b = pwdata[15:0];
					REG_W1_LOW:  cfg.w1_lo = pwdata[15:0];
					REG_W1_HIGH: cfg.w1_hi = pwdata[15:0];
					REG_W2_LOW:  cfg.w2_lo = pwdata[15:0];
					REG_W2_HIGH: cfg.w2_hi = pwdata[15:0];
					default: begin
					end
				endcase
			end
			outstanding = predicted_reports.size();
		end
	end

endmodule

[verif/coincidence_histogram_2d_windows_test.sv]
// Top of the coincidence histogram test: clock, reset, APB setup, command words
// and result back-pressure. Depends on chist2d_pkg, the block and chist2d_report_check.
module coincidence_histogram_2d_windows_test;
	import chist2d_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int LIMIT_CYCLES = 1500000;
	localparam int RAND_PHASES  = 6;
	localparam int PHASE_WORDS  = 330;
	localparam int HOLD_AT      = 700;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 40;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid, in_ready;
	logic [1:0]         cmd;
	logic [EN_W-1:0]    energy_a, energy_b;
	logic [RC_W-1:0]    read_row, read_col;
	logic               out_valid, out_ready;
	logic [RC_W-1:0]    row, col;
	logic [CNT_W-1:0]   bin_count, both_in_one, both_in_two, both_in_union, crossed_windows;

	int mismatches, outstanding, records_seen, reads_seen, clears_seen, results_checked;
	int words_sent = 0;
	int cycle_count = 0;
	cfg_t setup;

	coincidence_histogram_2d_windows u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.energy_a(energy_a), .energy_b(energy_b), .read_row(read_row), .read_col(read_col),
		.out_valid(out_valid), .out_ready(out_ready), .row(row), .col(col),
		.bin_count(bin_count), .both_in_one(both_in_one), .both_in_two(both_in_two),
		.both_in_union(both_in_union), .crossed_windows(crossed_windows)
	);

	chist2d_report_check u_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.energy_a(energy_a), .energy_b(energy_b), .read_row(read_row), .read_col(read_col),
		.out_valid(out_valid), .out_ready(out_ready), .row(row), .col(col),
		.bin_count(bin_count), .both_in_one(both_in_one), .both_in_two(both_in_two),
		.both_in_union(both_in_union), .crossed_windows(crossed_windows),
		.mismatches(mismatches), .outstanding(outstanding), .records_seen(records_seen),
		.reads_seen(reads_seen), .clears_seen(clears_seen),
		.results_checked(results_checked)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// stop a hung run
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[coincidence_histogram_2d_windows] ERROR");
		$finish;
	end

	// result side: random stalls, a calm stretch now and then, one long hold-off
	initial begin
		int gap;
		int taken;
		taken = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = ((taken / 150) % 4 == 3) ? 0 : $urandom_range(0, 13);
			if (taken == HOLD_AT)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	function automatic int bins_used(input logic [NBINS_W-1:0] n);
		return (n > MAX_BINS) ? MAX_BINS : ((n == 0) ? 1 : int'(n));
	endfunction

	function automatic logic [NBINS_W-1:0] pick_bins();
		case ($urandom_range(0, 7))
			0: return 8'd1;
			1: return 8'd128;
			2: return 8'($urandom_range(2, 8));
			3: return 8'($urandom_range(129, 255));
			4: return 8'd0;
			default: return 8'($urandom_range(1, 128));
		endcase
	endfunction

	function automatic logic [EN_W-1:0] pick_width();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3: return 16'($urandom);
			4, 5: return 16'($urandom_range(1, 16));
			default: return 16'($urandom_range(1, 600));
		endcase
	endfunction

	// window near a base edge, now and then empty or the full range
	function automatic void pick_window(input int base, output logic [EN_W-1:0] lo,
			output logic [EN_W-1:0] hi);
		int l, h;
		l = base + $urandom_range(0, 3000);
		h = l + $urandom_range(0, 2000);
		if ($urandom_range(0, 5) == 0)
			h = $urandom_range(0, 65535);
		if ($urandom_range(0, 7) == 0) begin
			l = 0;
			h = 65535;
		end
		lo = EN_W'((l > 65535) ? 65535 : l);
		hi = EN_W'((h > 65535) ? 65535 : h);
	endfunction

	function automatic cfg_t random_setup();
		cfg_t s;
		s.bins_a = pick_bins();
		s.bins_b = pick_bins();
		s.width_a = pick_width();
		s.width_b = pick_width();
		pick_window(0, s.w1_lo, s.w1_hi);
		pick_window($urandom_range(0, 1) ? int'(s.w1_lo) : 0, s.w2_lo, s.w2_hi);
		return s;
	endfunction

	// energy per axis: raw, in the binned span, at a window edge, in a window, 0 or FFFF
	function automatic logic [EN_W-1:0] pick_energy(input cfg_t s, input logic axis_b);
		logic [EN_W-1:0] w;
		logic [NBINS_W-1:0] n;
		int span, edge_v;
		w = axis_b ? s.width_b : s.width_a;
		n = axis_b ? s.bins_b : s.bins_a;
		case ($urandom_range(0, 9))
			0, 1: return EN_W'($urandom);
			2, 3, 4: begin
				span = bins_used(n) * ((w == 0) ? 1 : int'(w)) + int'(w);
				return EN_W'($urandom_range(0, (span > 65535) ? 65535 : span));
			end
			5, 6: begin
				case ($urandom_range(0, 3))
					0: edge_v = s.w1_lo;
					1: edge_v = s.w1_hi;
					2: edge_v = s.w2_lo;
					default: edge_v = s.w2_hi;
				endcase
				edge_v = edge_v + int'($urandom_range(0, 2)) - 1;
				return EN_W'((edge_v < 0) ? 0 : ((edge_v > 65535) ? 65535 : edge_v));
			end
			7, 8: begin
				if ($urandom_range(0, 1) && s.w1_lo < s.w1_hi)
					return EN_W'($urandom_range(s.w1_lo, s.w1_hi - 1));
				if (s.w2_lo < s.w2_hi)
					return EN_W'($urandom_range(s.w2_lo, s.w2_hi - 1));
				return EN_W'($urandom);
			end
			default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		endcase
	endfunction

	// offer one command word after a random gap; returns at a falling edge
	task automatic send_word(input op_t c, input logic [EN_W-1:0] ea, input logic [EN_W-1:0] eb,
			input logic [RC_W-1:0] rr, input logic [RC_W-1:0] rc);
		int gap;
		gap = ((words_sent / 120) % 5 == 2) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		energy_a <= ea;
		energy_b <= eb;
		read_row <= rr;
		read_col <= rc;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic record_pair(input logic [EN_W-1:0] ea, input logic [EN_W-1:0] eb);
		send_word(OP_RECORD, ea, eb, RC_W'($urandom), RC_W'($urandom));
	endtask

	task automatic read_bin(input logic [RC_W-1:0] rr, input logic [RC_W-1:0] rc);
		send_word(OP_READ, EN_W'($urandom), EN_W'($urandom), rr, rc);
	endtask

	// drop valid and wait until every predicted word has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_setup(input cfg_t s);
		write_reg(REG_BINS_A, PDATA_W'(s.bins_a));
		write_reg(REG_BINS_B, PDATA_W'(s.bins_b));
		write_reg(REG_WIDTH_A, PDATA_W'(s.width_a));
		write_reg(REG_WIDTH_B, PDATA_W'(s.width_b));
		write_reg(REG_W1_LOW, PDATA_W'(s.w1_lo));
		write_reg(REG_W1_HIGH, PDATA_W'(s.w1_hi));
		write_reg(REG_W2_LOW, PDATA_W'(s.w2_lo));
		write_reg(REG_W2_HIGH, PDATA_W'(s.w2_hi));
	endtask

	initial begin
		int pick;
		int clears_left;
		int fails;
		logic [RC_W-1:0] rr, rc;
		clears_left = 6;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		cmd = OP_RECORD;
		energy_a = '0;
		energy_b = '0;
		read_row = '0;
		read_col = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: empty windows, default bins and widths
		record_pair(16'h0000, 16'h0000);
		record_pair(16'hFFFF, 16'hFFFF);
		read_bin(7'd99, 7'd99);
		read_bin(7'd127, 7'd127);
		send_word(OP_NONE, EN_W'($urandom), EN_W'($urandom), RC_W'($urandom), RC_W'($urandom));
		wait_drained();

		// zero bins and zero width on A, oversized bins on B, an empty second window
		// fields: bins_a, bins_b, width_a, width_b, w1 low/high, w2 low/high
		setup = {8'd0, 8'd255, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'd100, 16'd100};
		load_setup(setup);
		record_pair(16'hFFFF, 16'd200);
		record_pair(16'h0000, 16'h0000);
		record_pair(16'hFFFE, 16'd127);
		read_bin(7'd0, 7'd127);
		read_bin(7'd0, 7'd0);
		wait_drained();

		// full bins and widest width on A, one bin and zero width on B,
		// overlapping windows probed at their edges, then a clear
		setup = {8'd128, 8'd1, 16'hFFFF, 16'd0, 16'd10, 16'd20, 16'd15, 16'hFFFF};
		load_setup(setup);
		record_pair(16'd10, 16'd19);
		record_pair(16'd15, 16'd15);
		record_pair(16'd19, 16'd20);
		record_pair(16'd20, 16'd10);
		record_pair(16'hFFFF, 16'hFFFE);
		record_pair(16'd9, 16'd14);
		read_bin(7'd0, 7'd0);
		read_bin(7'd1, 7'd0);
		send_word(OP_CLEAR, EN_W'($urandom), EN_W'($urandom), RC_W'($urandom), RC_W'($urandom));
		read_bin(7'd0, 7'd0);
		record_pair(16'd100, 16'd100);
		send_word(OP_NONE, EN_W'($urandom), EN_W'($urandom), RC_W'($urandom), RC_W'($urandom));

		// random phases, each under a fresh setting
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			wait_drained();
			setup = random_setup();
			load_setup(setup);
			repeat (PHASE_WORDS) begin
				pick = $urandom_range(0, 99);
				if (pick >= 98 && clears_left > 0 && $urandom_range(0, 7) == 0) begin
					clears_left--;
					send_word(OP_CLEAR, EN_W'($urandom), EN_W'($urandom), RC_W'($urandom),
						RC_W'($urandom));
				end else if (pick >= 70 && pick < 94) begin
					// aim about half of the reads at bins in use
					if ($urandom_range(0, 1)) begin
						rr = RC_W'($urandom_range(0, bins_used(setup.bins_a) - 1));
						rc = RC_W'($urandom_range(0, bins_used(setup.bins_b) - 1));
					end else begin
						rr = RC_W'($urandom);
						rc = RC_W'($urandom);
					end
					read_bin(rr, rc);
				end else if (pick >= 94 && pick < 98) begin
					send_word(OP_NONE, EN_W'($urandom), EN_W'($urandom), RC_W'($urandom),
						RC_W'($urandom));
				end else begin
					record_pair(pick_energy(setup, 1'b0), pick_energy(setup, 1'b1));
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		fails = mismatches + outstanding;
		$display("Run covered %0d records, %0d bin reads and %0d clears under %0d settings;",
			records_seen, reads_seen, clears_seen, RAND_PHASES + 3);
		$display("%0d result words checked, with random stalls and one %0d-cycle output hold.",
			results_checked, HOLD_CYCLES);
		if (fails == 0)
			$display("[coincidence_histogram_2d_windows] OK");
		else
			$display("[coincidence_histogram_2d_windows] ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/chist2d_pkg.sv
src/chist2d_div.sv
src/chist2d_regs.sv
src/chist2d_ctrl.sv
src/chist2d_dp.sv
src/coincidence_histogram_2d_windows.sv
src/chist2d_chk.sv
verif/chist2d_report_check.sv
verif/coincidence_histogram_2d_windows_test.sv
